[sv/ts_adaptation_field_parser_macros.svh]
// Assertion macros for the adaptation field parser.
// Define ASSERT_OFF to compile the assertions out.
`ifndef TS_ADAPTATION_FIELD_PARSER_MACROS_SVH
`define TS_ADAPTATION_FIELD_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge, disabled while reset is held.
`define TSAF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, including during reset.
`define TSAF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TSAF_ASSERT(label, clk, rst_n, prop, msg)
`define TSAF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[sv/tsaf_pkg.sv]
`default_nettype none

package tsaf_pkg;

  // Adaptation flags byte, bit positions
  localparam int unsigned FlagExt    = 0;
  localparam int unsigned FlagPriv   = 1;
  localparam int unsigned FlagSplice = 2;
  localparam int unsigned FlagOpcr   = 3;
  localparam int unsigned FlagPcr    = 4;

  // Extension part flags (upper nibble of the extension flags byte)
  localparam int unsigned PartNoDesc   = 0;
  localparam int unsigned PartSeamless = 1;
  localparam int unsigned PartRate     = 2;
  localparam int unsigned PartLtw      = 3;

  localparam int unsigned PcrBytes = 6;
  localparam int unsigned OpcrBytes = 6;

  // Error codes carried in the summary
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrExtZero   = 3'd1;
  localparam logic [2:0] ErrExtShort  = 3'd2;
  localparam logic [2:0] ErrBadDesc   = 3'd3;
  localparam logic [2:0] ErrTruncated = 3'd4;

  // Record kinds
  localparam logic KindDescHdr = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 72;

  typedef struct packed {
    logic        kind;
    logic [7:0]  dlen;
    logic [7:0]  dtag;
    logic [2:0]  err;
    logic [8:0]  pcr_ext;
    logic [32:0] base33;
    logic [7:0]  flags;
    logic        last;
  } rec_t;

endpackage

`default_nettype wire

[sv/ts_adaptation_field_parser.sv]
// Channel | Direction | Transaction contents
// --------+-----------+-------------------------------------------------------------
// in_     | slave     | tdata[7:0] data_byte, tlast last_byte
// out_    | master    | tdata: flag_bits, PCR base, pcr_extension, error_code,
//         |           |   descriptor_tag, descriptor_length; tuser record_kind;
//         |           |   tlast last_of_run
//
// A byte is registered at its accepting edge and parsed once the queue has room for two
// records; the byte's records (none, one or two) go to a three-entry output queue.
// A byte is taken every cycle unless one waits in the input register while the queue holds
// two or more records, so a byte yielding two records can stall the next one even with
// out_tready high; in_tready depends on registers only.
// Synchronous active-low reset clears the input stage, parser state and queue count.
`default_nettype none
`include "ts_adaptation_field_parser_macros.svh"

module ts_adaptation_field_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [tsaf_pkg::InDataW-1:0]   in_tdata,   // [7:0] data_byte
  input  wire logic                           in_tlast,   // last_byte
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [7:0] flag_bits, [40:8] PCR base, [49:41] pcr_extension, [52:50] error_code,
  // [60:53] descriptor_tag, [68:61] descriptor_length, [71:69] zero
  output      logic [tsaf_pkg::OutDataW-1:0]  out_tdata,
  output      logic                           out_tuser,  // [0] record_kind
  output      logic                           out_tlast   // last_of_run
);

  import tsaf_pkg::*;

  typedef enum logic [3:0] {
    PH_FLAGS,
    PH_PCR,
    PH_OPCR,
    PH_SPLICE,
    PH_PRIV_LEN,
    PH_PRIV_SKIP,
    PH_EXT_LEN,
    PH_EXT_FLAGS,
    PH_PART_SKIP,
    PH_DESC_TAG,
    PH_DESC_LEN,
    PH_DESC_SKIP,
    PH_IGNORE
  } phase_t;

  localparam int unsigned QDepth = 3;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Next phase once the flags byte or PCR is done, walking down the optional fields.
  function automatic phase_t after_splice(input logic [7:0] f);
    return f[FlagPriv] ? PH_PRIV_LEN : PH_EXT_LEN;
  endfunction

  function automatic phase_t after_opcr(input logic [7:0] f);
    return f[FlagSplice] ? PH_SPLICE : after_splice(f);
  endfunction

  function automatic phase_t after_pcr(input logic [7:0] f);
    phase_t p;
    if (!f[FlagExt]) begin
      p = PH_IGNORE;
    end else if (f[FlagOpcr]) begin
      p = PH_OPCR;
    end else begin
      p = after_opcr(f);
    end
    return p;
  endfunction

  function automatic phase_t desc_start(input logic [7:0] left);
    return (left != 8'd0) ? PH_DESC_TAG : PH_IGNORE;
  endfunction

  // Input register stage
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Parser state
  phase_t      phase_r,    phase_nxt;
  logic [7:0]  skip_r,     skip_nxt;
  logic [7:0]  flags_r,    flags_nxt;
  logic [32:0] base33_r,   base33_nxt;
  logic [8:0]  pcr_ext_r,  pcr_ext_nxt;
  logic [7:0]  ext_left_r, ext_left_nxt;
  logic [3:0]  parts_r,    parts_nxt;
  logic [7:0]  tag_r,      tag_nxt;
  logic [2:0]  err_r,      err_nxt;

  // Output queue; entry 0 drives the out_ channel
  rec_t             q_r [QDepth];
  rec_t             q_nxt [QDepth];
  logic [QCntW-1:0] q_cnt_r, q_cnt_nxt;

  logic       proc_fire;
  logic       pop;
  logic       hdr_vld;
  logic [1:0] push_n;
  rec_t       rec0, rec1, hdr_rec, sum_rec;
  logic [2:0] sum_err;

  // Room for two records is required before a byte is parsed
  assign proc_fire = in_vld_r && (q_cnt_r <= QCntW'(QDepth - 2));
  assign in_tready = !in_vld_r || proc_fire;
  assign pop       = out_tvalid && out_tready;

  // Per-byte parse
  always_comb begin
    logic [7:0] b;
    logic [7:0] left_v;
    logic [3:0] sum_v;
    logic       bad_v;
    b            = in_byte_r;
    left_v       = ext_left_r;
    sum_v        = 4'd0;
    bad_v        = 1'b0;
    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    flags_nxt    = flags_r;
    base33_nxt   = base33_r;
    pcr_ext_nxt  = pcr_ext_r;
    ext_left_nxt = ext_left_r;
    parts_nxt    = parts_r;
    tag_nxt      = tag_r;
    err_nxt      = err_r;
    hdr_vld      = 1'b0;

    unique case (phase_r)
      PH_FLAGS: begin
        flags_nxt   = b;
        base33_nxt  = '0;
        pcr_ext_nxt = '0;
        if (b[FlagPcr]) begin
          phase_nxt = PH_PCR;
          skip_nxt  = 8'(PcrBytes);
        end else begin
          phase_nxt = after_pcr(b);
          if (phase_nxt == PH_OPCR) skip_nxt = 8'(OpcrBytes);
        end
      end
      PH_PCR: begin
        // Six bytes: 33 bits of base, 6 reserved, 9 bits of extension
        if (skip_r > 8'd2) begin
          base33_nxt = {base33_r[24:0], b};
        end else if (skip_r == 8'd2) begin
          base33_nxt  = {base33_r[31:0], b[7]};
          pcr_ext_nxt = {b[0], 8'h00};
        end else begin
          pcr_ext_nxt = {pcr_ext_r[8], b};
        end
        skip_nxt = skip_r - 8'd1;
        if (skip_r == 8'd1) begin
          phase_nxt = after_pcr(flags_r);
          if (phase_nxt == PH_OPCR) skip_nxt = 8'(OpcrBytes);
        end
      end
      PH_OPCR: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_r == 8'd1) phase_nxt = after_opcr(flags_r);
      end
      PH_SPLICE: begin
        phase_nxt = after_splice(flags_r);
      end
      PH_PRIV_LEN: begin
        if (b == 8'd0) begin
          phase_nxt = PH_EXT_LEN;
        end else begin
          skip_nxt  = b;
          phase_nxt = PH_PRIV_SKIP;
        end
      end
      PH_PRIV_SKIP: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_r == 8'd1) phase_nxt = PH_EXT_LEN;
      end
      PH_EXT_LEN: begin
        if (b == 8'd0) begin
          if (err_r == ErrNone) err_nxt = ErrExtZero;
          phase_nxt = PH_IGNORE;
        end else begin
          ext_left_nxt = b - 8'd1;
          phase_nxt    = PH_EXT_FLAGS;
        end
      end
      PH_EXT_FLAGS: begin
        // ltw (2), piecewise rate (3), seamless splice (3), checked in that order
        parts_nxt = b[7:4];
        if (b[4+PartLtw]) begin
          if (left_v < 8'd2) begin
            bad_v = 1'b1;
          end else begin
            left_v = left_v - 8'd2;
            sum_v  = sum_v + 4'd2;
          end
        end
        if (!bad_v && b[4+PartRate]) begin
          if (left_v < 8'd3) begin
            bad_v = 1'b1;
          end else begin
            left_v = left_v - 8'd3;
            sum_v  = sum_v + 4'd3;
          end
        end
        if (!bad_v && b[4+PartSeamless]) begin
          if (left_v < 8'd3) begin
            bad_v = 1'b1;
          end else begin
            left_v = left_v - 8'd3;
            sum_v  = sum_v + 4'd3;
          end
        end
        ext_left_nxt = left_v;
        if (bad_v) begin
          if (err_r == ErrNone) err_nxt = ErrExtShort;
          phase_nxt = PH_IGNORE;
        end else if (sum_v != 4'd0) begin
          skip_nxt  = {4'd0, sum_v};
          phase_nxt = PH_PART_SKIP;
        end else begin
          phase_nxt = b[4+PartNoDesc] ? PH_IGNORE : desc_start(left_v);
        end
      end
      PH_PART_SKIP: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_r == 8'd1) begin
          phase_nxt = parts_r[PartNoDesc] ? PH_IGNORE : desc_start(ext_left_r);
        end
      end
      PH_DESC_TAG: begin
        tag_nxt   = b;
        phase_nxt = PH_DESC_LEN;
      end
      PH_DESC_LEN: begin
        if ((b == 8'd0) || (({1'b0, b} + 9'd2) > {1'b0, ext_left_r})) begin
          if (err_r == ErrNone) err_nxt = ErrBadDesc;
          phase_nxt = PH_IGNORE;
        end else begin
          hdr_vld      = 1'b1;
          ext_left_nxt = ext_left_r - (b + 8'd2);
          skip_nxt     = b;
          phase_nxt    = PH_DESC_SKIP;
        end
      end
      PH_DESC_SKIP: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_r == 8'd1) phase_nxt = desc_start(ext_left_r);
      end
      default: begin
        phase_nxt = PH_IGNORE;
      end
    endcase

    // Summary is built from the updated latches, before the end-of-field reset
    sum_err = err_nxt;
    if ((err_nxt == ErrNone) && (phase_nxt != PH_IGNORE)) sum_err = ErrTruncated;

    hdr_rec = '{kind: KindDescHdr, dlen: b, dtag: tag_r, err: ErrNone,
                pcr_ext: pcr_ext_r, base33: base33_r, flags: flags_r,
                last: !in_last_r};
    sum_rec = '{kind: KindSummary, dlen: 8'd0, dtag: 8'd0, err: sum_err,
                pcr_ext: pcr_ext_nxt, base33: base33_nxt, flags: flags_nxt,
                last: 1'b1};

    if (in_last_r) begin
      phase_nxt    = PH_FLAGS;
      skip_nxt     = '0;
      flags_nxt    = '0;
      base33_nxt   = '0;
      pcr_ext_nxt  = '0;
      ext_left_nxt = '0;
      parts_nxt    = '0;
      tag_nxt      = '0;
      err_nxt      = ErrNone;
    end
  end

  // Records produced by this byte, in output order
  always_comb begin
    rec0   = hdr_vld ? hdr_rec : sum_rec;
    rec1   = sum_rec;
    push_n = 2'd0;
    if (proc_fire) begin
      push_n = 2'(hdr_vld) + 2'(in_last_r);
    end
  end

  // Queue update: shift on pop, append behind the surviving entries
  always_comb begin
    logic [QCntW-1:0] base;
    base = q_cnt_r - QCntW'(pop);
    for (int i = 0; i < QDepth; i++) begin
      if ((push_n != 2'd0) && (QCntW'(i) == base)) begin
        q_nxt[i] = rec0;
      end else if ((push_n == 2'd2) && (QCntW'(i) == base + QCntW'(1))) begin
        q_nxt[i] = rec1;
      end else if (pop && (i < QDepth - 1)) begin
        q_nxt[i] = q_r[(i < QDepth - 1) ? i + 1 : i];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    q_cnt_nxt = base + QCntW'(push_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      q_cnt_r    <= '0;
      phase_r    <= PH_FLAGS;
      skip_r     <= '0;
      flags_r    <= '0;
      base33_r   <= '0;
      pcr_ext_r  <= '0;
      ext_left_r <= '0;
      parts_r    <= '0;
      tag_r      <= '0;
      err_r      <= ErrNone;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      q_cnt_r <= q_cnt_nxt;
      if (proc_fire) begin
        phase_r    <= phase_nxt;
        skip_r     <= skip_nxt;
        flags_r    <= flags_nxt;
        base33_r   <= base33_nxt;
        pcr_ext_r  <= pcr_ext_nxt;
        ext_left_r <= ext_left_nxt;
        parts_r    <= parts_nxt;
        tag_r      <= tag_nxt;
        err_r      <= err_nxt;
      end
    end
    // Payload registers, qualified by the valid bits above
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    for (int i = 0; i < QDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_tvalid = (q_cnt_r != '0);
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;
  assign out_tdata  = {3'b000, q_r[0].dlen, q_r[0].dtag, q_r[0].err,
                       q_r[0].pcr_ext, q_r[0].base33, q_r[0].flags};

  `TSAF_ASSERT(a_q_bound, clk, rst_n, (q_cnt_r <= QCntW'(QDepth)),
               "output queue overflow")
  `TSAF_ASSERT(a_sum_last, clk, rst_n,
               (out_tvalid && (out_tuser == KindSummary)) |-> out_tlast,
               "summary record without tlast")
  `TSAF_ASSERT(a_hdr_noerr, clk, rst_n,
               (out_tvalid && (out_tuser == KindDescHdr)) |-> (out_tdata[52:50] == ErrNone),
               "descriptor record carries an error code")
  `TSAF_ASSERT(a_last_reset, clk, rst_n,
               (proc_fire && in_last_r) |=> ((phase_r == PH_FLAGS) && (err_r == ErrNone)),
               "parser not back at flags byte after field end")
  `TSAF_ASSERT(a_err_ignore, clk, rst_n, (err_r != ErrNone) |-> (phase_r == PH_IGNORE),
               "error latched while still parsing")

endmodule

`default_nettype wire
